[rtl/ltkm_pkg.sv]
// ----------------------------------------------------------------------------
// ltkm_pkg
// shared widths, the item that climbs the cell chain and the sequencer states
// ----------------------------------------------------------------------------
package ltkm_pkg;

	// lane count follows the four-bit lane field
	localparam int LANE_W = 4;
	localparam int VAL_W  = 31;
	localparam int LANES  = 1 << LANE_W;
	localparam int LEVELS = LANE_W;

	// entry moving one tree level per cycle
	typedef struct packed {
		logic              valid;
		logic              build;
		logic [LANE_W-1:0] lane;
		logic [VAL_W-1:0]  value;
	} item_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_BUILD,
		ST_MERGE,
		ST_BUSY
	} state_t;

endpackage

[rtl/ltkm_head_if.sv]
// ----------------------------------------------------------------------------
// ltkm_head_if
// request channel carrying one lane head value
// ----------------------------------------------------------------------------
interface ltkm_head_if;
	logic                      valid;
	logic                      ready;
	logic [ltkm_pkg::LANE_W-1:0] lane;
	logic [ltkm_pkg::VAL_W-1:0]  value;

	modport source (output valid, output lane, output value, input ready);
	modport sink (input valid, input lane, input value, output ready);
endinterface

[rtl/ltkm_result_if.sv]
// ----------------------------------------------------------------------------
// ltkm_result_if
// result channel carrying one merged element
// ----------------------------------------------------------------------------
interface ltkm_result_if;
	logic                      valid;
	logic                      ready;
	logic [ltkm_pkg::VAL_W-1:0]  out_value;
	logic [ltkm_pkg::LANE_W-1:0] out_lane;
	logic                      done_res;

	modport source (output valid, output out_value, output out_lane, output done_res,
		input ready);
	modport sink (input valid, input out_value, input out_lane, input done_res,
		output ready);
endinterface

[rtl/ltkm_heads.sv]
// ----------------------------------------------------------------------------
// ltkm_heads
// head value store, one write port, one registered read port
// ----------------------------------------------------------------------------
module ltkm_heads (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ltkm_pkg::LANE_W-1:0] wr_addr,
	input  logic [ltkm_pkg::VAL_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [ltkm_pkg::LANE_W-1:0] rd_addr,
	output logic [ltkm_pkg::VAL_W-1:0]  rd_data
);
	import ltkm_pkg::*;

	logic [VAL_W-1:0] mem_q [LANES];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/ltkm_cell.sv]
// ----------------------------------------------------------------------------
// ltkm_cell
// one tree level: holds the losers of its nodes and plays one match a cycle
// ----------------------------------------------------------------------------
module ltkm_cell #(
	parameter int LEVEL = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ltkm_pkg::item_t up,
	output ltkm_pkg::item_t down
);
	import ltkm_pkg::*;

	localparam int NODES = LANES >> (LEVEL + 1);
	localparam int IW    = (NODES > 1) ? $clog2(NODES) : 1;

	logic [LANE_W-1:0] node_lane_q [NODES];
	logic [VAL_W-1:0]  node_val_q [NODES];
	logic [LANE_W-1:0] hold_lane_q;
	logic [VAL_W-1:0]  hold_val_q;
	logic              pair_q;
	logic              down_v_q;
	logic              down_build_q;
	logic [LANE_W-1:0] down_lane_q;
	logic [VAL_W-1:0]  down_val_q;

	logic [LANE_W-1:0] shifted;
	logic [IW-1:0]     idx;
	logic [LANE_W-1:0] oth_lane;
	logic [VAL_W-1:0]  oth_val;
	logic              wr_en;
	logic [LANE_W-1:0] los_lane;
	logic [VAL_W-1:0]  los_val;
	logic [LANE_W-1:0] win_lane;
	logic [VAL_W-1:0]  win_val;
	logic              emit;

	// node within this level: the lane bits above the level
	assign shifted  = up.lane >> (LEVEL + 1);
	assign idx      = shifted[IW-1:0];
	assign oth_lane = node_lane_q[idx];
	assign oth_val  = node_val_q[idx];

	always_comb begin
		wr_en    = 1'b0;
		los_lane = up.lane;
		los_val  = up.value;
		win_lane = up.lane;
		win_val  = up.value;
		emit     = 1'b0;
		if (up.valid) begin
			if (up.build) begin
				// second of a pair: held entry is the left child
				if (pair_q) begin
					wr_en = 1'b1;
					emit  = 1'b1;
					if (hold_val_q > up.value) begin
						win_lane = hold_lane_q;
						win_val  = hold_val_q;
					end else begin
						los_lane = hold_lane_q;
						los_val  = hold_val_q;
					end
				end
			end else begin
				// replay: climbing entry keeps ties
				emit = 1'b1;
				if (up.value < oth_val) begin
					wr_en    = 1'b1;
					win_lane = oth_lane;
					win_val  = oth_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q   <= 1'b0;
			down_v_q <= 1'b0;
		end else begin
			down_v_q <= emit;
			if (up.valid && up.build) begin
				pair_q <= ~pair_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid && up.build && !pair_q) begin
			hold_lane_q <= up.lane;
			hold_val_q  <= up.value;
		end
		if (wr_en) begin
			node_lane_q[idx] <= los_lane;
			node_val_q[idx]  <= los_val;
		end
		down_build_q <= up.build;
		down_lane_q  <= win_lane;
		down_val_q   <= win_val;
	end

	assign down = '{valid: down_v_q, build: down_build_q, lane: down_lane_q,
		value: down_val_q};

endmodule

[rtl/loser_tree_kway_merge_top.sv]
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top
// merges sixteen descending zero-terminated streams through a loser tree
// ----------------------------------------------------------------------------
//  channel  dir  payload                          accepted when
//  head     in   lane[3:0], value[30:0]           head.valid & head.ready
//  result   out  out_value[30:0], out_lane[3:0],  result.valid & result.ready
//                done_res
//
// the last fill request of a fill phase starts a build
// that streams all sixteen heads out of the head store (one read a cycle)
// through the read register and the four level cells to the winner at the root.
// a merge request climbs the cell chain one level a cycle through the four cell
// stages; the next request is taken only after the winner leaves the root cell.
// reset clears the sequencer, counters and valid flags; the head store and the
// loser nodes are undefined until written.
// a waiting result sits in the output register, a second one in a skid stage;
// head.ready drops only while the skid stage is occupied or work is in flight.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top (
	input  logic          clk,
	input  logic          arst_n,
	ltkm_head_if.sink     head,
	ltkm_result_if.source result
);
	import ltkm_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [LANE_W-1:0] fill_cnt_q;
	logic [LANE_W-1:0] rd_ptr_q;
	logic [LANE_W-1:0] winner_q;

	// head store read pipeline
	logic              rd_v_s1;
	logic [LANE_W-1:0] rd_lane_s1;
	logic [VAL_W-1:0]  rd_data;

	// output register and skid stage
	logic              out_v_q;
	logic [LANE_W-1:0] out_lane_q;
	logic [VAL_W-1:0]  out_val_q;
	logic              skid_v_q;
	logic [LANE_W-1:0] skid_lane_q;
	logic [VAL_W-1:0]  skid_val_q;

	item_t chain [LEVELS+1];

	logic acc;
	logic fill_wr;
	logic merge_hit;
	logic rd_en;
	logic rd_last;
	logic res_v;
	logic out_free;

	// request handshake
	assign head.ready = ((state_q == ST_FILL) || (state_q == ST_MERGE)) && !skid_v_q;
	assign acc        = head.valid && head.ready;

	// every four-bit lane is in range, so every fill request counts
	assign fill_wr   = acc && (state_q == ST_FILL);
	// a merge request for any lane but the winner is dropped
	assign merge_hit = acc && (state_q == ST_MERGE) && (head.lane == winner_q);

	assign rd_en   = (state_q == ST_BUILD);
	assign rd_last = rd_en && (rd_ptr_q == LANE_W'(LANES - 1));

	ltkm_heads u_heads (
		.clk     (clk),
		.wr_en   (fill_wr || merge_hit),
		.wr_addr (head.lane),
		.wr_data (head.value),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// entry into the chain: build heads in lane order, or the refilled winner
	always_comb begin
		chain[0] = '0;
		if (rd_v_s1) begin
			chain[0] = '{valid: 1'b1, build: 1'b1, lane: rd_lane_s1, value: rd_data};
		end else if (merge_hit) begin
			chain[0] = '{valid: 1'b1, build: 1'b0, lane: head.lane, value: head.value};
		end
	end

	// one cell per tree level, leaves first, root last
	for (genvar g = 0; g < LEVELS; g++) begin : g_level
		ltkm_cell #(
			.LEVEL (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.up     (chain[g]),
			.down   (chain[g+1])
		);
	end

	assign res_v = chain[LEVELS].valid;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (fill_wr && (fill_cnt_q == LANE_W'(LANES - 1))) begin
					state_d = ST_BUILD;
				end
			end
			ST_BUILD: begin
				if (rd_last) begin
					state_d = ST_BUSY;
				end
			end
			ST_MERGE: begin
				if (merge_hit) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				// a zero winner means every stream is spent
				if (res_v) begin
					state_d = (chain[LEVELS].value == '0) ? ST_FILL : ST_MERGE;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			fill_cnt_q <= '0;
			rd_ptr_q   <= '0;
			winner_q   <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			// wraps to zero on the last head, ready for the next fill phase
			if (fill_wr) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res_v) begin
				winner_q <= chain[LEVELS].lane;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_lane_s1 <= rd_ptr_q;
	end

	// output register with skid stage
	assign out_free = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= res_v;
				end else begin
					out_v_q <= res_v;
				end
			end else if (res_v) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_lane_q <= skid_lane_q;
				out_val_q  <= skid_val_q;
				if (res_v) begin
					skid_lane_q <= chain[LEVELS].lane;
					skid_val_q  <= chain[LEVELS].value;
				end
			end else if (res_v) begin
				out_lane_q <= chain[LEVELS].lane;
				out_val_q  <= chain[LEVELS].value;
			end
		end else if (res_v) begin
			skid_lane_q <= chain[LEVELS].lane;
			skid_val_q  <= chain[LEVELS].value;
		end
	end

	assign result.valid     = out_v_q;
	assign result.out_value = out_val_q;
	assign result.out_lane  = out_lane_q;
	assign result.done_res  = (out_val_q == '0);

endmodule

[tb/loser_tree_kway_merge_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top_tb
// self-checking bench for the sixteen-lane loser-tree merge: head requests are
// driven with random gaps, every accepted request is fed to a behavioural copy
// of the tree, and each merged element leaving the block is checked against it
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top_tb;
	import ltkm_pkg::*;

	localparam int          ITEMS       = 1200;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 60;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam bit [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};

	// one merged element as the block should present it
	typedef struct {
		bit [VAL_W-1:0]  value;
		bit [LANE_W-1:0] lane;
		bit              done;
	} merged_elem_t;

	// behavioural copy of the tournament tree plus the queue of due elements
	class merge_scoreboard;
		bit [VAL_W-1:0]  heads [LANES];
		bit [LANE_W-1:0] losers [LANES];
		bit [LANE_W-1:0] winner = '0;
		int              fill_count = 0;
		bit              merging = 1'b0;
		merged_elem_t    due [$];
		int              errors = 0;

		function void build_tree();
			bit [LANE_W-1:0] win [2*LANES];
			bit [LANE_W-1:0] l, r;
			for (int i = 0; i < LANES; i++)
				win[LANES+i] = LANE_W'(i);
			for (int i = LANES - 1; i > 0; i--) begin
				l = win[2*i];
				r = win[2*i+1];
				if (heads[l] > heads[r]) begin
					win[i] = l;
					losers[i] = r;
				end else begin
					win[i] = r;
					losers[i] = l;
				end
			end
			winner = win[1];
		endfunction

		function void replay_from(bit [LANE_W-1:0] leaf);
			int              node;
			bit [LANE_W-1:0] cur, other;
			cur = leaf;
			node = (int'(leaf) + LANES) / 2;
			while (node != 0) begin
				other = losers[node];
				// climbing entry keeps ties
				if (heads[cur] < heads[other]) begin
					losers[node] = cur;
					cur = other;
				end
				node = node / 2;
			end
			winner = cur;
		endfunction

		function void push_winner();
			merged_elem_t e;
			e.value = heads[winner];
			e.lane  = winner;
			e.done  = (e.value == '0);
			due.push_back(e);
			if (e.done) begin
				merging = 1'b0;
				fill_count = 0;
			end else
				merging = 1'b1;
		endfunction

		function void note_head(bit [LANE_W-1:0] lane, bit [VAL_W-1:0] value);
			if (!merging) begin
				heads[lane] = value;
				fill_count++;
				if (fill_count < LANES)
					return;
				build_tree();
				push_winner();
			end else begin
				if (lane != winner)
					return;
				heads[lane] = value;
				replay_from(lane);
				push_winner();
			end
		endfunction

		function void check_result(logic [VAL_W-1:0] value, logic [LANE_W-1:0] lane,
				logic done);
			merged_elem_t e;
			if (due.size() == 0) begin
				$error("unexpected result: out_value %0d out_lane %0d done_res %0b",
					value, lane, done);
				errors++;
				return;
			end
			e = due.pop_front();
			if (value !== e.value) begin
				$error("out_value mismatch: expected %0d, got %0d", e.value, value);
				errors++;
			end
			if (lane !== e.lane) begin
				$error("out_lane mismatch: expected %0d, got %0d", e.lane, lane);
				errors++;
			end
			if (done !== e.done) begin
				$error("done_res mismatch: expected %0b, got %0b", e.done, done);
				errors++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	int unsigned     cycles = 0;
	int              idle_pct = 33;   // chance in a hundred that a side idles
	int              hold_asks = 0;   // long receiver hold-offs requested so far
	merge_scoreboard sb;

	ltkm_head_if   head_ch ();
	ltkm_result_if result_ch ();

	loser_tree_kway_merge_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_ch),
		.result (result_ch)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run guard: a correct run finishes far below this
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result monitor, values sampled as they stood before the edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			sb.check_result(result_ch.out_value, result_ch.out_lane,
				result_ch.done_res);
	end

	// result sink: random back-pressure, and a long hold-off whenever the
	// stimulus asks for one, counted here so the sender keeps pushing meanwhile
	initial begin : result_sink
		int served;
		int hold_left;
		served = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left == 0 && served != hold_asks) begin
				served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else
				result_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// offer one head request after a random gap and wait for it to be taken;
	// the copy of the tree is updated at the acceptance edge so the next
	// request can be built from the new winner
	task automatic send_head(input bit [LANE_W-1:0] lane, input bit [VAL_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			head_ch.valid <= 1'b0;
			@(posedge clk);
		end
		head_ch.valid <= 1'b1;
		head_ch.lane  <= lane;
		head_ch.value <= value;
		do
			@(posedge clk);
		while (head_ch.ready !== 1'b1);
		sb.note_head(lane, value);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// one complete merge: a fill phase, then refills of the winning lane until
	// every stream is exhausted; values mostly descend, with some noise
	task automatic run_stream_set(input int unsigned top, inout int counted);
		bit [LANE_W-1:0] order [LANES];
		bit [LANE_W-1:0] lane, tmp;
		bit [VAL_W-1:0]  v, cur;
		bit              all_zero, shuffled;
		int              j, r;
		all_zero = ($urandom_range(19) == 0);
		shuffled = 1'($urandom_range(1));
		for (int i = 0; i < LANES; i++)
			order[i] = LANE_W'(i);
		for (int i = LANES - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		// fill: every lane once, or random lanes where repeats overwrite
		for (int i = 0; i < LANES; i++) begin
			lane = shuffled ? order[i] : LANE_W'($urandom_range(LANES - 1));
			v = (all_zero || $urandom_range(7) == 0) ? '0 : VAL_W'($urandom_range(top, 1));
			send_head(lane, v);
			counted++;
		end
		while (sb.merging) begin
			r = $urandom_range(99);
			lane = sb.winner;
			cur = sb.heads[lane];
			if (r < 4) begin
				// request for a lane that did not win, to be dropped
				lane = lane ^ LANE_W'($urandom_range(LANES - 1, 1));
				v = VAL_W'($urandom_range(top));
			end else begin
				if (r < 7)
					v = VAL_W'($urandom_range(top));     // out of order value
				else if (r < 22)
					v = '0;                              // stream exhausted
				else
					v = VAL_W'($urandom_range(cur));     // next element, ties allowed
				counted++;
			end
			send_head(lane, v);
		end
	endtask

	initial begin : stimulus
		int          counted;
		int          set_no;
		int unsigned top;
		counted = 0;
		set_no = 0;
		sb = new();
		arst_n <= 1'b0;
		head_ch.valid <= 1'b0;
		head_ch.lane  <= '0;
		head_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every lane written once after reset, extremes of the value
		// field, a tie between the outermost lanes at build time (right wins)
		for (int i = 0; i < LANES; i++) begin
			case (i)
				0, LANES - 1: send_head(LANE_W'(i), VAL_MAX);
				5:            send_head(LANE_W'(i), 31'h2AAA_AAAA);
				6:            send_head(LANE_W'(i), 31'h5555_5555);
				default:      send_head(LANE_W'(i), '0);
			endcase
		end
		send_head(LANE_W'(0), VAL_W'(5));        // not the winner, dropped
		send_head(LANE_W'(LANES - 1), VAL_MAX);  // tie on replay, climbing lane stays on top
		send_head(LANE_W'(LANES - 1), '0);
		send_head(LANE_W'(0), '0);
		send_head(LANE_W'(6), '0);
		send_head(LANE_W'(5), '0);               // last live lane drained, done result
		counted = LANES + 5;

		// random merges over a spread of value ranges; narrow ranges force ties
		while (counted < ITEMS) begin
			case (set_no % 5)
				0, 1:    top = VAL_MAX;
				2:       top = 1000;
				3:       top = 7;
				default: top = 1;
			endcase
			if (set_no == 2)
				hold_asks++;
			if (set_no == 5) begin
				// sender goes quiet until every due element has left
				head_ch.valid <= 1'b0;
				wait_drained();
			end
			idle_pct = (set_no == 7 || set_no == 8) ? 0 : 33;
			run_stream_set(top, counted);
			set_no++;
		end
		head_ch.valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
